// File: src/quoted_argument_tokenizer_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef QUOTED_ARGUMENT_TOKENIZER_UNIT_DEFINES_SVH
`define QUOTED_ARGUMENT_TOKENIZER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define QAT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("quoted argument tokenizer check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define QAT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("quoted argument tokenizer check failed");

`endif

// File: src/qat_pkg.sv
`default_nettype none

package qat_pkg;

	// Result kinds
	localparam logic [1:0] KIND_CHAR = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_LINE = 2'd2;

	// Open quote codes
	localparam logic [1:0] QUOTE_NONE   = 2'd0;
	localparam logic [1:0] QUOTE_SINGLE = 2'd1;
	localparam logic [1:0] QUOTE_DOUBLE = 2'd2;

	// Character codes
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;

	// Configuration port
	localparam int          CFG_ADDR_W   = 3;
	localparam int          CFG_DATA_W   = 32;
	localparam logic        REG_MAX_ARGS = 1'b0;
	localparam logic [5:0]  MAX_ARGS_RST = 6'd16;

	// One queued entry: which results to send, in order char, end, line
	typedef struct packed {
		logic       emit_char;
		logic       emit_end;
		logic       emit_line;
		logic [7:0] ch;
		logic [5:0] idx;
		logic [5:0] count;
	} cmd_t;

	// Queue fill status
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

// File: src/qat_front.sv
`default_nettype none

module qat_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire logic [7:0]      ch,
	input  wire logic            line_end,
	input  wire logic [5:0]      max_args,
	output qat_pkg::cmd_t        cmd,
	output logic                 push
);

	logic       in_arg_q;
	logic [1:0] quote_q;
	logic       esc_q;
	logic [5:0] count_q;

	logic       in_arg_d;
	logic [1:0] quote_d;
	logic       esc_d;
	logic [5:0] count_d;

	logic       is_sep;
	logic       is_quote;
	logic [1:0] q_code;
	logic [5:0] idx;

	// Classify the character
	assign is_sep = (ch == qat_pkg::CH_SPACE) || (ch == qat_pkg::CH_TAB) ||
		(ch == qat_pkg::CH_LF) || (ch == qat_pkg::CH_CR);
	assign is_quote = (ch == qat_pkg::CH_SQUOTE) || (ch == qat_pkg::CH_DQUOTE);
	assign q_code = (ch == qat_pkg::CH_SQUOTE) ? qat_pkg::QUOTE_SINGLE : qat_pkg::QUOTE_DOUBLE;

	// Work out next state and the results this item causes
	always_comb begin
		in_arg_d = in_arg_q;
		quote_d  = quote_q;
		esc_d    = esc_q;
		count_d  = count_q;
		idx      = count_q - 6'd1;
		cmd      = '0;
		if (line_end) begin
			cmd.emit_char = in_arg_q && esc_q;
			cmd.ch        = (in_arg_q && esc_q) ? qat_pkg::CH_BSLASH : 8'd0;
			cmd.emit_end  = in_arg_q;
			cmd.emit_line = 1'b1;
			cmd.idx       = idx;
			cmd.count     = count_q;
			in_arg_d = 1'b0;
			quote_d  = qat_pkg::QUOTE_NONE;
			esc_d    = 1'b0;
			count_d  = '0;
		end else if (in_arg_q || (!is_sep && (count_q < max_args))) begin
			// Open a new argument when none is open
			if (!in_arg_q) begin
				in_arg_d = 1'b1;
				quote_d  = qat_pkg::QUOTE_NONE;
				esc_d    = 1'b0;
				count_d  = count_q + 6'd1;
			end
			idx     = count_d - 6'd1;
			cmd.idx = idx;
			if (esc_d) begin
				esc_d         = 1'b0;
				cmd.emit_char = 1'b1;
				cmd.ch        = ch;
			end else if ((quote_d == qat_pkg::QUOTE_NONE) && is_sep) begin
				in_arg_d     = 1'b0;
				cmd.emit_end = 1'b1;
			end else if (ch == qat_pkg::CH_BSLASH) begin
				esc_d = 1'b1;
			end else if (is_quote) begin
				if (quote_d == qat_pkg::QUOTE_NONE) begin
					quote_d = q_code;
				end else if (quote_d == q_code) begin
					quote_d = qat_pkg::QUOTE_NONE;
				end else begin
					cmd.emit_char = 1'b1;
					cmd.ch        = ch;
				end
			end else begin
				cmd.emit_char = 1'b1;
				cmd.ch        = ch;
			end
		end
	end

	assign push = accept && (cmd.emit_char || cmd.emit_end || cmd.emit_line);

	// Advance parser state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_arg_q <= 1'b0;
			quote_q  <= qat_pkg::QUOTE_NONE;
			esc_q    <= 1'b0;
			count_q  <= '0;
		end else if (accept) begin
			in_arg_q <= in_arg_d;
			quote_q  <= quote_d;
			esc_q    <= esc_d;
			count_q  <= count_d;
		end
	end

endmodule

`default_nettype wire

// File: src/qat_queue.sv
`default_nettype none

module qat_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire qat_pkg::cmd_t push_cmd,
	input  wire logic          pop,
	output qat_pkg::cmd_t      head,
	output qat_pkg::q_status_t status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	qat_pkg::cmd_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;

	assign head         = mem_q[rd_ptr_q];
	assign status.full  = (fill_q == CNT_W'(DEPTH));
	assign status.empty = (fill_q == '0);

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: src/qat_back.sv
`default_nettype none

module qat_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire qat_pkg::cmd_t      head,
	input  wire qat_pkg::q_status_t status,
	output logic                    pop,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [15:0]             m_tdata,
	output logic [1:0]              m_tuser,
	output logic                    m_tlast
);

	logic [2:0]  done_q;
	logic        m_tvalid_q;
	logic [15:0] m_tdata_q;
	logic [1:0]  m_tuser_q;
	logic        m_tlast_q;

	logic [2:0]  pending;
	logic [2:0]  pick;
	logic [2:0]  rest;
	logic        is_last;
	logic        advance;
	logic [1:0]  kind;
	logic [7:0]  o_char;
	logic [5:0]  o_idx;

	// Pick the next result of the head entry: char, then end, then line
	assign pending = {head.emit_line, head.emit_end, head.emit_char} & ~done_q;
	always_comb begin
		pick   = 3'b000;
		kind   = qat_pkg::KIND_LINE;
		o_char = 8'd0;
		o_idx  = head.count;
		if (pending[0]) begin
			pick   = 3'b001;
			kind   = qat_pkg::KIND_CHAR;
			o_char = head.ch;
			o_idx  = head.idx;
		end else if (pending[1]) begin
			pick  = 3'b010;
			kind  = qat_pkg::KIND_END;
			o_idx = head.idx;
		end else begin
			pick = 3'b100;
		end
	end

	assign rest    = pending & ~pick;
	assign is_last = (rest == 3'b000);
	assign advance = !status.empty && (!m_tvalid_q || m_tready);
	assign pop     = advance && is_last;

	// Track results already sent from the head entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
		end else if (advance) begin
			done_q <= is_last ? 3'b000 : (done_q | pick);
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata_q <= {2'b00, o_idx, o_char};
			m_tuser_q <= kind;
			m_tlast_q <= is_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

`default_nettype wire

// File: src/quoted_argument_tokenizer_unit.sv
// Channel  Dir  Fields (tdata from bit 0 up)          tuser   tlast
// s_axis   in   ch[7:0]                               -       line_end
// m_axis   out  out_char[7:0], arg_index[13:8], 0 pad kind    last
// apb      in   max_args at byte address 0            -       -
//
// One character is accepted per cycle while the queue has room; parser state
// updates in that cycle. Each result leaves the output register one per cycle
// unless stalled, so line end makes up to three results; the entry queue
// (QUEUE_DEPTH entries) absorbs the burst. s_tready drops only when it is full.
// arst_n clears parser state, queue and output valid; max_args resets to 16.
`default_nettype none

module quoted_argument_tokenizer_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// s_axis_tdata: ch[7:0]
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [7:0]                      s_axis_tdata,
	input  wire logic                            s_axis_tlast,
	// m_axis_tdata: out_char[7:0], arg_index[13:8], zero [15:14]
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	output logic [15:0]                          m_axis_tdata,
	// m_axis_tuser: kind[1:0]
	output logic [1:0]                           m_axis_tuser,
	output logic                                 m_axis_tlast,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [qat_pkg::CFG_ADDR_W-1:0]  paddr,
	input  wire logic [qat_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [qat_pkg::CFG_DATA_W-1:0]       prdata,
	output logic                                 pready
);

	logic               max_args_sel;
	logic [5:0]         max_args_reg_q;
	logic               accept;
	logic               push;
	logic               pop;
	qat_pkg::cmd_t      push_cmd;
	qat_pkg::cmd_t      head;
	qat_pkg::q_status_t status;

	// Register file
	assign pready       = 1'b1;
	assign max_args_sel = (paddr[2] == qat_pkg::REG_MAX_ARGS);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_args_reg_q <= qat_pkg::MAX_ARGS_RST;
		end else if (psel && penable && pwrite && pready && max_args_sel) begin
			max_args_reg_q <= pwdata[5:0];
		end
	end
	assign prdata = max_args_sel ? {26'd0, max_args_reg_q} : '0;

	// Accept characters while the queue has room
	assign s_axis_tready = !status.full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	qat_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.ch       (s_axis_tdata),
		.line_end (s_axis_tlast),
		.max_args (max_args_reg_q),
		.cmd      (push_cmd),
		.push     (push)
	);

	qat_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.status   (status)
	);

	qat_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.status   (status),
		.pop      (pop),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_tdata  (m_axis_tdata),
		.m_tuser  (m_axis_tuser),
		.m_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire

// File: src/qat_checker.sv
`default_nettype none
`include "quoted_argument_tokenizer_unit_defines.svh"

module qat_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [15:0] m_axis_tdata,
	input wire logic [1:0]  m_axis_tuser,
	input wire logic        m_axis_tlast
);

	// A line-finished result always closes the transaction group
	`QAT_ASSERT_NOW(line_is_last, m_axis_tvalid && (m_axis_tuser == qat_pkg::KIND_LINE), m_axis_tlast)

	// Only character results carry a character
	`QAT_ASSERT_NOW(char_zero, m_axis_tvalid && (m_axis_tuser != qat_pkg::KIND_CHAR), m_axis_tdata[7:0] == 8'd0)

	// An argument end that is not last is followed by the line-finished result
	`QAT_ASSERT_NEXT(end_then_line, m_axis_tvalid && m_axis_tready && !m_axis_tlast && (m_axis_tuser == qat_pkg::KIND_END), !m_axis_tvalid || (m_axis_tuser == qat_pkg::KIND_LINE))

	// A stalled result holds
	`QAT_ASSERT_NEXT(out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind quoted_argument_tokenizer_unit qat_checker u_checker (.*);

`default_nettype wire

// File: test/quoted_argument_tokenizer_unit_tb.sv
module quoted_argument_tokenizer_unit_tb;
	import qat_pkg::*;

	localparam logic [CFG_ADDR_W-1:0] ADDR_MAX_ARGS = {REG_MAX_ARGS, 2'b00};
	localparam int SINK_HOLD_CYCLES = 60;
	localparam int DRAIN_CYCLES     = 8;
	localparam int RANDOM_CHARS     = 430;

	// One output transaction as seen on the master side
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_char;
		logic [5:0] arg_index;
		logic       last;
	} token_t;

	// Directed stimulus row: a character, or a write of the argument limit
	typedef struct packed {
		bit           is_cfg;
		logic [5:0]   limit;
		logic [7:0]   ch;
		logic         eol;
		bit           typed;
		logic [1:0]   n;
		token_t [2:0] res;
	} stim_row_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'h00;
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr  = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic        pready;

	// Tokenizer shadow state
	logic       tk_in_arg;
	logic [1:0] tk_quote;
	logic       tk_escape;
	logic [5:0] tk_count;
	logic [5:0] tk_limit;

	token_t    token_out[$];
	token_t    expected_tokens[$];
	stim_row_t directed_rows[$];
	int        mismatches     = 0;
	int        chars_sent     = 0;
	bit        throttle_on    = 1'b1;
	bit        sink_hold_req  = 1'b0;

	quoted_argument_tokenizer_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop in case the pipeline hangs
	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic token_t tok(logic [1:0] kind, logic [7:0] c, logic [5:0] idx,
			logic last = 1'b0);
		token_t t;
		t.kind      = kind;
		t.out_char  = c;
		t.arg_index = idx;
		t.last      = last;
		return t;
	endfunction

	function automatic bit is_blank(logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
	endfunction

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(0, 3))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_LF;
			default: return CH_CR;
		endcase
	endfunction

	// Any byte that is not a separator, a backslash or a quote
	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255));
		while (is_blank(c) || c == CH_BSLASH || c == CH_SQUOTE || c == CH_DQUOTE);
		return c;
	endfunction

	// Advance the shadow tokenizer by one character, leave its results in token_out
	function automatic void tokenize(logic [7:0] c, logic eol);
		logic [5:0] idx;
		logic [1:0] q;
		token_out.delete();
		if (eol) begin
			idx = tk_count - 6'd1;
			if (tk_in_arg) begin
				if (tk_escape)
					token_out.push_back(tok(KIND_CHAR, CH_BSLASH, idx));
				token_out.push_back(tok(KIND_END, 8'h00, idx));
			end
			token_out.push_back(tok(KIND_LINE, 8'h00, tk_count));
			tk_in_arg = 1'b0;
			tk_quote  = QUOTE_NONE;
			tk_escape = 1'b0;
			tk_count  = 6'd0;
		end else if (tk_in_arg || !(is_blank(c) || tk_count >= tk_limit)) begin
			// open a new argument on its first character
			if (!tk_in_arg) begin
				tk_in_arg = 1'b1;
				tk_quote  = QUOTE_NONE;
				tk_escape = 1'b0;
				tk_count  = tk_count + 6'd1;
			end
			idx = tk_count - 6'd1;
			q = (c == CH_SQUOTE) ? QUOTE_SINGLE : QUOTE_DOUBLE;
			if (tk_escape) begin
				tk_escape = 1'b0;
				token_out.push_back(tok(KIND_CHAR, c, idx));
			end else if (tk_quote == QUOTE_NONE && is_blank(c)) begin
				tk_in_arg = 1'b0;
				token_out.push_back(tok(KIND_END, 8'h00, idx));
			end else if (c == CH_BSLASH) begin
				tk_escape = 1'b1;
			end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
				if (tk_quote == QUOTE_NONE)
					tk_quote = q;
				else if (tk_quote == q)
					tk_quote = QUOTE_NONE;
				else
					token_out.push_back(tok(KIND_CHAR, c, idx));
			end else begin
				token_out.push_back(tok(KIND_CHAR, c, idx));
			end
		end
		if (token_out.size() > 0)
			token_out[token_out.size() - 1].last = 1'b1;
	endfunction

	function automatic void add_row(logic [7:0] c, logic eol, int n = -1,
			token_t r0 = '0, token_t r1 = '0, token_t r2 = '0);
		stim_row_t row;
		row        = '0;
		row.ch     = c;
		row.eol    = eol;
		row.typed  = (n >= 0);
		row.n      = (n < 0) ? 2'd0 : 2'(n);
		row.res[0] = r0;
		row.res[1] = r1;
		row.res[2] = r2;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_limit(logic [5:0] v);
		stim_row_t row;
		row        = '0;
		row.is_cfg = 1'b1;
		row.limit  = v;
		directed_rows.push_back(row);
	endfunction

	function automatic void note_mismatch(string what, token_t want, token_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%s: expected kind %0d char %02h index %0d last %0d, got kind %0d char %02h index %0d last %0d",
				what, want.kind, want.out_char, want.arg_index, want.last,
				got.kind, got.out_char, got.arg_index, got.last);
	endfunction

	// Offer one character, wait for the transaction, then queue its results
	task automatic offer(logic [7:0] c, logic eol, bit typed = 1'b0, int n = 0,
			token_t [2:0] typed_res = '0);
		if (throttle_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tlast  <= eol;
		do @(posedge clk); while (!s_axis_tready);
		chars_sent++;
		tokenize(c, eol);
		if (typed) begin
			for (int k = 0; k < n; k++)
				expected_tokens.push_back(typed_res[k]);
		end else begin
			foreach (token_out[k])
				expected_tokens.push_back(token_out[k]);
		end
	endtask

	// Drop valid and let the block drain before touching the register
	task automatic quiesce();
		s_axis_tvalid <= 1'b0;
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic check_arg_limit(logic [5:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_MAX_ARGS;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[5:0] !== v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("max_args readback: expected %0d, got %0d", v, prdata[5:0]);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Write max_args, then read it back in a back-to-back transfer
	task automatic set_arg_limit(logic [5:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_MAX_ARGS;
		pwdata  <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		tk_limit = v;
		check_arg_limit(v);
	endtask

	task automatic send_random_line();
		logic [7:0] q;
		repeat ($urandom_range(1, 8)) begin
			case ($urandom_range(0, 9))
				0, 1, 2: repeat ($urandom_range(1, 4)) offer(plain_char(), 1'b0);
				3, 4: offer(pick_blank(), 1'b0);
				5, 6: begin
					// quoted group, occasionally left open
					q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
					offer(q, 1'b0);
					repeat ($urandom_range(0, 4)) begin
						case ($urandom_range(0, 3))
							0: offer((q == CH_SQUOTE) ? CH_DQUOTE : CH_SQUOTE, 1'b0);
							1: offer(pick_blank(), 1'b0);
							2: begin
								offer(CH_BSLASH, 1'b0);
								offer(8'($urandom_range(0, 255)), 1'b0);
							end
							default: offer(plain_char(), 1'b0);
						endcase
					end
					if ($urandom_range(0, 7) != 0)
						offer(q, 1'b0);
				end
				7: begin
					offer(CH_BSLASH, 1'b0);
					offer(8'($urandom_range(0, 255)), 1'b0);
				end
				default: offer(8'($urandom_range(0, 255)), 1'b0);
			endcase
		end
		if ($urandom_range(0, 5) == 0)
			offer(CH_BSLASH, 1'b0);
		offer(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// Output side: random stalls plus one long hold on request
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (SINK_HOLD_CYCLES) @(posedge clk);
			end else if (throttle_on && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	// Compare each output transaction with the oldest expected token
	always @(posedge clk) begin : check_tokens
		token_t got;
		token_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = tok(m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[13:8], m_axis_tlast);
			if (expected_tokens.size() == 0) begin
				note_mismatch("unexpected token", '0, got);
			end else begin
				want = expected_tokens.pop_front();
				if (got.kind !== want.kind || got.out_char !== want.out_char ||
						got.arg_index !== want.arg_index || got.last !== want.last)
					note_mismatch("token mismatch", want, got);
			end
		end
	end

	initial begin
		logic [5:0] lim;

		tk_in_arg = 1'b0;
		tk_quote  = QUOTE_NONE;
		tk_escape = 1'b0;
		tk_count  = 6'd0;
		tk_limit  = MAX_ARGS_RST;

		// First an empty line, then a line with every character class, escapes and quotes
		add_row(8'h00, 1'b1, 1, tok(KIND_LINE, 8'h00, 6'd0, 1'b1));
		add_row(8'h61, 1'b0, 1, tok(KIND_CHAR, 8'h61, 6'd0, 1'b1));
		add_row(8'hFF, 1'b0, 1, tok(KIND_CHAR, 8'hFF, 6'd0, 1'b1));
		add_row(8'h00, 1'b0, 1, tok(KIND_CHAR, 8'h00, 6'd0, 1'b1));
		add_row(CH_SPACE, 1'b0, 1, tok(KIND_END, 8'h00, 6'd0, 1'b1));
		add_row(CH_TAB, 1'b0, 0);
		add_row(CH_SQUOTE, 1'b0, 0);
		add_row(CH_DQUOTE, 1'b0, 1, tok(KIND_CHAR, CH_DQUOTE, 6'd1, 1'b1));
		add_row(CH_SQUOTE, 1'b0, 0);
		add_row(CH_BSLASH, 1'b0, 0);
		add_row(CH_SQUOTE, 1'b0, 1, tok(KIND_CHAR, CH_SQUOTE, 6'd1, 1'b1));
		add_row(CH_CR, 1'b0, 1, tok(KIND_END, 8'h00, 6'd1, 1'b1));
		add_row(CH_DQUOTE, 1'b0, 0);
		add_row(CH_DQUOTE, 1'b0, 0);
		add_row(CH_LF, 1'b0, 1, tok(KIND_END, 8'h00, 6'd2, 1'b1));
		add_row(CH_DQUOTE, 1'b0, 0);
		add_row(CH_BSLASH, 1'b0, 0);
		// line end with a quote open and a backslash pending
		add_row(8'hFF, 1'b1, 3, tok(KIND_CHAR, CH_BSLASH, 6'd3),
			tok(KIND_END, 8'h00, 6'd3), tok(KIND_LINE, 8'h00, 6'd4, 1'b1));
		// lower the limit in the middle of an argument
		add_row(8'h70, 1'b0);
		add_row(CH_SPACE, 1'b0);
		add_row(8'h71, 1'b0);
		add_limit(6'd1);
		add_row(CH_SPACE, 1'b0);
		add_row(8'h73, 1'b0);
		add_row(8'h00, 1'b1);
		// no arguments at all
		add_limit(6'd0);
		add_row(8'h61, 1'b0, 0);
		add_row(8'h00, 1'b1, 1, tok(KIND_LINE, 8'h00, 6'd0, 1'b1));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_arg_limit(MAX_ARGS_RST);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				quiesce();
				set_arg_limit(directed_rows[i].limit);
			end else begin
				offer(directed_rows[i].ch, directed_rows[i].eol, directed_rows[i].typed,
					directed_rows[i].n, directed_rows[i].res);
			end
		end

		// Top limit, a line past it, and a long output hold to back up the queue
		quiesce();
		set_arg_limit(6'd63);
		sink_hold_req = 1'b1;
		repeat (66) begin
			offer(plain_char(), 1'b0);
			offer(pick_blank(), 1'b0);
		end
		offer(8'($urandom_range(0, 255)), 1'b1);

		// Random lines under a mix of limits; the tail runs without throttling
		while (chars_sent < RANDOM_CHARS) begin
			case ($urandom_range(0, 3))
				0: lim = 6'd1;
				1: lim = 6'd63;
				default: lim = 6'($urandom_range(2, 62));
			endcase
			quiesce();
			set_arg_limit(lim);
			repeat ($urandom_range(2, 4)) begin
				if (chars_sent > RANDOM_CHARS - 60)
					throttle_on = 1'b0;
				send_random_line();
			end
		end

		quiesce();
		if (mismatches == 0 && expected_tokens.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+src
src/qat_pkg.sv
src/qat_front.sv
src/qat_queue.sv
src/qat_back.sv
src/quoted_argument_tokenizer_unit.sv
src/qat_checker.sv
test/quoted_argument_tokenizer_unit_tb.sv
